// File: sv/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg: shared types and constants for the Pareto front filter
// Holds the field widths, the stored entry layout, the per-lane result type
// and the domination compare used by every lane.
// ----------------------------------------------------------------------------
`default_nettype none

package pff_pkg;

    // Fixed widths of the transaction fields.
    localparam int SLOT_BITS    = 3;
    localparam int MAIN_BITS    = 4;
    localparam int VALUE_KINDS  = 10;
    localparam int VALUE_BITS   = 16;
    localparam int MASK_BITS    = 10;
    localparam int REMOVED_BITS = 7;
    localparam int REMOVED_MAX  = (1 << REMOVED_BITS) - 1;

    // Main kinds that are accepted whatever the effective mask says.
    localparam logic [MAIN_BITS-1:0] MAIN_EXEMPT_A = MAIN_BITS'(3);
    localparam logic [MAIN_BITS-1:0] MAIN_EXEMPT_B = MAIN_BITS'(6);

    // Defaults for the top level parameters.
    localparam int DEF_ENTRIES_PER_SLOT = 64;
    localparam int DEF_SLOT_COUNT       = 5;
    localparam int DEF_LANE_COUNT       = 4;

    typedef logic [VALUE_KINDS-1:0][VALUE_BITS-1:0] value_vec_t;

    typedef struct packed {
        logic                 valid;
        logic [MAIN_BITS-1:0] main;
        value_vec_t           values;
    } entry_t;

    // Control from the sequencer to one lane.
    typedef struct packed {
        logic rd_en;
        logic cmp_en;
        logic live;
        logic ext_wr_en;
        logic ext_wr_valid;
    } lane_ctrl_t;

    // What one lane found for the entry it compared.
    typedef struct packed {
        logic dom;
        logic removed;
        logic is_free;
    } lane_res_t;

    // Running summary of one scan.
    typedef struct packed {
        logic                    dom;
        logic                    found;
        logic [REMOVED_BITS-1:0] removed;
    } merge_sum_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // True when a is at least b in every selected value kind.
    function automatic logic covers(input value_vec_t a, input value_vec_t b,
                                    input logic [VALUE_KINDS-1:0] kinds);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < VALUE_KINDS; k++) begin
            if (kinds[k] && (a[k] < b[k])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: sv/pff_lane.sv
// ----------------------------------------------------------------------------
// pff_lane: one compare lane with its own entry bank
// Holds every LANE_COUNT-th entry of each slot table, reads one entry per
// cycle, checks domination both ways and clears entries the offer covers.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_lane
    import pff_pkg::*;
#(
    parameter int ENTRIES_PER_SLOT = DEF_ENTRIES_PER_SLOT,
    parameter int SLOT_COUNT       = DEF_SLOT_COUNT,
    parameter int LANE_COUNT       = DEF_LANE_COUNT
) (
    input  wire logic                                  clk,
    input  wire lane_ctrl_t                            ctrl,
    input  wire logic [addr_bits(SLOT_COUNT *
        ((ENTRIES_PER_SLOT + LANE_COUNT - 1) / LANE_COUNT))-1:0] rd_addr,
    input  wire logic [addr_bits(SLOT_COUNT *
        ((ENTRIES_PER_SLOT + LANE_COUNT - 1) / LANE_COUNT))-1:0] ext_wr_addr,
    input  wire logic [MAIN_BITS-1:0]                  offer_main,
    input  wire value_vec_t                            offer_values,
    input  wire logic [VALUE_KINDS-1:0]                kinds,
    output      lane_res_t                             res
);

    localparam int ROWS   = (ENTRIES_PER_SLOT + LANE_COUNT - 1) / LANE_COUNT;
    localparam int DEPTH  = SLOT_COUNT * ROWS;
    localparam int ADDR_W = addr_bits(DEPTH);

    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    logic [ADDR_W-1:0]  addr_reg;
    lane_res_t          res_reg;

    logic               same_main;
    logic               dom_hit;
    logic               rm_hit;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    always_comb begin
        same_main = rdata_reg.valid && (rdata_reg.main == offer_main);
        dom_hit   = same_main && covers(rdata_reg.values, offer_values, kinds);
        rm_hit    = same_main && covers(offer_values, rdata_reg.values, kinds);

        // A removal writes back the entry it just read; otherwise the
        // sequencer owns the write port (clearing pass or append).
        if (ctrl.cmp_en && rm_hit) begin
            wr_en          = 1'b1;
            wr_addr        = addr_reg;
            wr_data        = rdata_reg;
            wr_data.valid  = 1'b0;
        end else begin
            wr_en          = ctrl.ext_wr_en;
            wr_addr        = ext_wr_addr;
            wr_data.valid  = ctrl.ext_wr_valid;
            wr_data.main   = offer_main;
            wr_data.values = offer_values;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
        end
        res_reg.dom     <= ctrl.cmp_en && dom_hit;
        res_reg.removed <= ctrl.cmp_en && rm_hit;
        res_reg.is_free <= ctrl.cmp_en && ctrl.live && (!rdata_reg.valid || rm_hit);
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: sv/pff_merge.sv
// ----------------------------------------------------------------------------
// pff_merge: combines lane results over one scan
// Ors the domination flags, counts removals with saturation and keeps the
// lowest free entry position seen after removals.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_merge
    import pff_pkg::*;
#(
    parameter int ENTRIES_PER_SLOT = DEF_ENTRIES_PER_SLOT,
    parameter int LANE_COUNT       = DEF_LANE_COUNT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  acc_en,
    input  wire logic [addr_bits((ENTRIES_PER_SLOT + LANE_COUNT - 1) /
        LANE_COUNT)-1:0]               row,
    input  wire lane_res_t             res [LANE_COUNT],
    output      merge_sum_t            sum,
    output      logic [addr_bits((ENTRIES_PER_SLOT + LANE_COUNT - 1) /
        LANE_COUNT)-1:0]               free_row,
    output      logic [addr_bits(LANE_COUNT)-1:0] free_lane
);

    localparam int ROWS   = (ENTRIES_PER_SLOT + LANE_COUNT - 1) / LANE_COUNT;
    localparam int ROW_W  = addr_bits(ROWS);
    localparam int LANE_W = addr_bits(LANE_COUNT);
    localparam int SUM_W  = REMOVED_BITS + 1;

    merge_sum_t          sum_reg;
    logic [ROW_W-1:0]    free_row_reg;
    logic [LANE_W-1:0]   free_lane_reg;

    logic                row_dom;
    logic                row_free;
    logic [LANE_W-1:0]   row_lane;
    logic [SUM_W-1:0]    row_pop;
    logic [SUM_W-1:0]    total;

    always_comb begin
        row_dom  = 1'b0;
        row_free = 1'b0;
        row_lane = '0;
        row_pop  = '0;
        for (int l = LANE_COUNT - 1; l >= 0; l--) begin
            row_dom = row_dom | res[l].dom;
            row_pop = row_pop + SUM_W'(res[l].removed);
            if (res[l].is_free) begin
                row_free = 1'b1;
                row_lane = LANE_W'(l);
            end
        end
        total = {1'b0, sum_reg.removed} + row_pop;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sum_reg <= '0;
        end else if (start) begin
            sum_reg <= '0;
        end else if (acc_en) begin
            sum_reg.dom <= sum_reg.dom | row_dom;
            if (total > SUM_W'(REMOVED_MAX)) begin
                sum_reg.removed <= REMOVED_BITS'(REMOVED_MAX);
            end else begin
                sum_reg.removed <= total[REMOVED_BITS-1:0];
            end
            if (!sum_reg.found && row_free) begin
                sum_reg.found <= 1'b1;
            end
        end
    end

    // Rows arrive in order, so the first row with a free lane is the lowest.
    always_ff @(posedge clk) begin
        if (acc_en && !sum_reg.found && row_free) begin
            free_row_reg  <= row;
            free_lane_reg <= row_lane;
        end
    end

    assign sum       = sum_reg;
    assign free_row  = free_row_reg;
    assign free_lane = free_lane_reg;

endmodule

`default_nettype wire

// File: sv/pareto_front_filter_unit.sv
// ----------------------------------------------------------------------------
// pareto_front_filter_unit: per-slot table of non-dominated candidates
// Offers are compared against their slot table by parallel lanes; covered
// entries are removed and an undominated offer is stored in the first
// free entry.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  cfg       in         cfg_write_en            cfg_write_data (effective mask)
//  offer     in         in_valid / in_stall     slot_kind, main_kind, value_*
//  result    out        out_valid / out_stall   appended .. table_full
//
// After reset the block clears its entry banks and holds in_stall high
// until the clearing pass is done.
// A scanned offer reads one row of LANE_COUNT entries per cycle through
// the single read port of each lane bank.
// A rejected or out-of-range offer skips the scan of its slot table.
// A result held by out_stall blocks completion of the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_front_filter_unit
    import pff_pkg::*;
#(
    parameter int ENTRIES_PER_SLOT = DEF_ENTRIES_PER_SLOT,
    parameter int SLOT_COUNT       = DEF_SLOT_COUNT,
    parameter int LANE_COUNT       = DEF_LANE_COUNT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_write_en,
    input  wire logic [MASK_BITS-1:0]    cfg_write_data,

    input  wire logic                    in_valid,
    output      logic                    in_stall,
    input  wire logic [SLOT_BITS-1:0]    slot_kind,
    input  wire logic [MAIN_BITS-1:0]    main_kind,
    input  wire logic [VALUE_BITS-1:0]   value_zero,
    input  wire logic [VALUE_BITS-1:0]   value_one,
    input  wire logic [VALUE_BITS-1:0]   value_two,
    input  wire logic [VALUE_BITS-1:0]   value_three,
    input  wire logic [VALUE_BITS-1:0]   value_four,
    input  wire logic [VALUE_BITS-1:0]   value_five,
    input  wire logic [VALUE_BITS-1:0]   value_six,
    input  wire logic [VALUE_BITS-1:0]   value_seven,
    input  wire logic [VALUE_BITS-1:0]   value_eight,
    input  wire logic [VALUE_BITS-1:0]   value_nine,

    output      logic                    out_valid,
    input  wire logic                    out_stall,
    output      logic                    appended,
    output      logic                    rejected_main,
    output      logic                    dominated,
    output      logic [REMOVED_BITS-1:0] removed_count,
    output      logic                    table_full
);

    localparam int ROWS       = (ENTRIES_PER_SLOT + LANE_COUNT - 1) / LANE_COUNT;
    localparam int DEPTH      = SLOT_COUNT * ROWS;
    localparam int ADDR_W     = addr_bits(DEPTH);
    localparam int ROW_W      = addr_bits(ROWS);
    localparam int LANE_W     = addr_bits(LANE_COUNT);
    localparam int LAST_LANES = ENTRIES_PER_SLOT - (ROWS - 1) * LANE_COUNT;
    localparam int SLOT_CMP_W = SLOT_BITS + 2;
    localparam int MASK_EXT_W = 1 << MAIN_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [MASK_BITS-1:0]    mask_reg;
    logic [MAIN_BITS-1:0]    offer_main_reg;
    value_vec_t              offer_values_reg;
    logic [ADDR_W-1:0]       slot_base_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        cmp_row_reg;
    logic [ROW_W-1:0]        mrg_row_reg;
    logic                    cmp_pend_reg;
    logic                    mrg_pend_reg;
    logic                    skip_reg;
    logic                    rej_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;

    logic                    out_valid_reg;
    logic                    appended_reg;
    logic                    rejected_main_reg;
    logic                    dominated_reg;
    logic [REMOVED_BITS-1:0] removed_count_reg;
    logic                    table_full_reg;

    logic                    in_acc;
    logic [MASK_EXT_W-1:0]   mask_ext;
    logic                    main_rej;
    logic                    slot_oor;
    logic                    row_last;
    logic                    clr_last;
    logic                    finish_go;
    logic                    append_go;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       ext_wr_addr;

    merge_sum_t              sum;
    logic [ROW_W-1:0]        free_row;
    logic [LANE_W-1:0]       free_lane;
    lane_ctrl_t              lane_ctrl [LANE_COUNT];
    lane_res_t               lane_res  [LANE_COUNT];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb begin
        mask_ext = MASK_EXT_W'(mask_reg);
        main_rej = !mask_ext[main_kind] && (main_kind != MAIN_EXEMPT_A)
                   && (main_kind != MAIN_EXEMPT_B);
        slot_oor = {2'b00, slot_kind} >= SLOT_CMP_W'(SLOT_COUNT);
    end

    assign row_last  = (row_reg == ROW_W'(ROWS - 1));
    assign clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign append_go = finish_go && !skip_reg && !sum.dom && sum.found;

    assign rd_addr     = slot_base_reg + ADDR_W'(row_reg);
    assign ext_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg
                                                 : slot_base_reg + ADDR_W'(free_row);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (main_rej || slot_oor) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (row_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!cmp_pend_reg && !mrg_pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            mask_reg      <= '0;
            clr_addr_reg  <= '0;
            row_reg       <= '0;
            cmp_pend_reg  <= 1'b0;
            mrg_pend_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_pend_reg <= (state_reg == ST_SCAN);
            mrg_pend_reg <= cmp_pend_reg;
            if (cfg_write_en) begin
                mask_reg <= cfg_write_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (in_acc) begin
                row_reg  <= '0;
                skip_reg <= main_rej || slot_oor;
                rej_reg  <= main_rej;
            end else if (state_reg == ST_SCAN) begin
                row_reg <= row_reg + ROW_W'(1);
            end
            if (finish_go) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc) begin
            offer_main_reg      <= main_kind;
            offer_values_reg[0] <= value_zero;
            offer_values_reg[1] <= value_one;
            offer_values_reg[2] <= value_two;
            offer_values_reg[3] <= value_three;
            offer_values_reg[4] <= value_four;
            offer_values_reg[5] <= value_five;
            offer_values_reg[6] <= value_six;
            offer_values_reg[7] <= value_seven;
            offer_values_reg[8] <= value_eight;
            offer_values_reg[9] <= value_nine;
            slot_base_reg       <= ADDR_W'(int'(slot_kind) * ROWS);
        end
        cmp_row_reg <= row_reg;
        mrg_row_reg <= cmp_row_reg;
        if (finish_go) begin
            appended_reg      <= append_go;
            rejected_main_reg <= rej_reg;
            dominated_reg     <= !skip_reg && sum.dom;
            removed_count_reg <= skip_reg ? '0 : sum.removed;
            table_full_reg    <= !skip_reg && !sum.dom && !sum.found;
        end
    end

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        // Only the last row of a slot can hold lanes past the table size.
        localparam bit ALWAYS_LIVE = (g < LAST_LANES);

        always_comb begin
            lane_ctrl[g].rd_en        = (state_reg == ST_SCAN);
            lane_ctrl[g].cmp_en       = cmp_pend_reg;
            lane_ctrl[g].live         = ALWAYS_LIVE || (cmp_row_reg != ROW_W'(ROWS - 1));
            lane_ctrl[g].ext_wr_en    = (state_reg == ST_CLEAR)
                                        || (append_go && (free_lane == LANE_W'(g)));
            lane_ctrl[g].ext_wr_valid = (state_reg != ST_CLEAR);
        end

        pff_lane #(
            .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT),
            .SLOT_COUNT       (SLOT_COUNT),
            .LANE_COUNT       (LANE_COUNT)
        ) u_lane (
            .clk          (clk),
            .ctrl         (lane_ctrl[g]),
            .rd_addr      (rd_addr),
            .ext_wr_addr  (ext_wr_addr),
            .offer_main   (offer_main_reg),
            .offer_values (offer_values_reg),
            .kinds        (mask_reg[VALUE_KINDS-1:0]),
            .res          (lane_res[g])
        );
    end

    pff_merge #(
        .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT),
        .LANE_COUNT       (LANE_COUNT)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_acc),
        .acc_en    (mrg_pend_reg),
        .row       (mrg_row_reg),
        .res       (lane_res),
        .sum       (sum),
        .free_row  (free_row),
        .free_lane (free_lane)
    );

    assign out_valid     = out_valid_reg;
    assign appended      = appended_reg;
    assign rejected_main = rejected_main_reg;
    assign dominated     = dominated_reg;
    assign removed_count = removed_count_reg;
    assign table_full    = table_full_reg;

endmodule

`default_nettype wire

// File: sv/pff_checker.sv
// ----------------------------------------------------------------------------
// pff_checker: port-level checks for the Pareto front filter
// Watches the result channel for outcomes that cannot occur together and for results that change while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_checker
    import pff_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic                    appended,
    input wire logic                    rejected_main,
    input wire logic                    dominated,
    input wire logic [REMOVED_BITS-1:0] removed_count,
    input wire logic                    table_full
);

    // A stalled result transaction stays up with appended, dominated, removed_count and table_full unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(appended)
            && $stable(dominated) && $stable(removed_count) && $stable(table_full))
        else $error("result changed while stalled");

    // A stored offer was neither dominated, dropped for room nor rejected.
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && appended |-> !dominated && !table_full && !rejected_main)
        else $error("appended together with a drop reason");

    // A rejected main kind touches no table.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected_main |-> !dominated && !table_full
            && (removed_count == '0))
        else $error("rejected offer reports table activity");

    // Room is only looked for when the offer was not dominated.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !dominated)
        else $error("table full reported for a dominated offer");

endmodule

bind pareto_front_filter_unit pff_checker u_pff_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .appended      (appended),
    .rejected_main (rejected_main),
    .dominated     (dominated),
    .removed_count (removed_count),
    .table_full    (table_full)
);

`default_nettype wire
